@@ hdl/hsvrgb_pkg.sv @@
`default_nettype none

package hsvrgb_pkg;

  localparam int unsigned PCT_W = 7;
  localparam int unsigned CH_W  = 8;
  localparam int unsigned HUE_W = 9;
  localparam int unsigned NUM_W = 20;
  localparam int unsigned MAG_W = 19;
  localparam int unsigned HEX_W = 48;

  typedef enum logic [0:0] {
    CFG_SATURATION = 1'b0,
    CFG_BRIGHTNESS = 1'b1
  } cfg_index_t;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // floor(p * 255 / 100) == (p * 5347860) >> 21 for every p up to 100.
  localparam int unsigned      PCT_PROD_W = 30;
  localparam int unsigned      PCT_SHIFT  = 21;
  localparam logic [22:0]      PCT_RECIP  = 23'd5347860;

  // floor(n / 60) == (n * 279621) >> 24 for every n below 381359.
  localparam int unsigned      DIV_PROD_W = 38;
  localparam int unsigned      DIV_SHIFT  = 24;
  localparam logic [18:0]      DIV60_RECIP = 19'd279621;

  localparam logic [HUE_W-1:0] RED_SPLIT     = 9'd180;
  localparam logic [HUE_W-1:0] RED_CENTER_LO = 9'd0;
  localparam logic [HUE_W-1:0] RED_CENTER_HI = 9'd360;
  localparam logic [HUE_W-1:0] GREEN_CENTER  = 9'd120;
  localparam logic [HUE_W-1:0] BLUE_CENTER   = 9'd240;

  localparam logic [NUM_W-1:0] HIGH_WEIGHT = 20'd120;
  localparam logic [NUM_W-1:0] LOW_WEIGHT  = 20'd60;

  function automatic logic [CH_W-1:0] pct_to_byte(input logic [PCT_W-1:0] pct);
    logic [PCT_PROD_W-1:0] prod;
    prod = PCT_PROD_W'(pct) * PCT_PROD_W'(PCT_RECIP);
    return prod[PCT_SHIFT +: CH_W];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] code;
    if (nib < 4'd10) begin
      code = 8'h30 + 8'(nib);
    end else begin
      code = 8'h57 + 8'(nib);
    end
    return code;
  endfunction

endpackage

`default_nettype wire

@@ hdl/hsv_to_rgb_hex_unit.sv @@
// HSV to RGB converter with hex text. Saturation and brightness are to be
// written through the configuration port only while the unit is idle; the
// unit itself does not enforce this. A write above 100 saturates to 100. A
// hue is taken on every cycle that start is high (busy is always low). Its
// result is on the outputs with done high for one cycle. The hue passes
// through the input register, after which each channel has a multiplier that
// forms its numerator; then the numerator register, after which a reciprocal
// multiplier divides by 60, the clamp is applied and the text is built; and
// last the result register. The unit sustains one hue per cycle and the
// receiver cannot stall it.
`default_nettype none

module hsv_to_rgb_hex_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [hsvrgb_pkg::HUE_W-1:0]  hue,
  input  wire logic                          wr_en,
  input  wire logic [0:0]                    wr_index,
  input  wire logic [hsvrgb_pkg::PCT_W-1:0]  wr_data,
  output logic                               done,
  output logic [hsvrgb_pkg::CH_W-1:0]        red,
  output logic [hsvrgb_pkg::CH_W-1:0]        green,
  output logic [hsvrgb_pkg::CH_W-1:0]        blue,
  output logic [hsvrgb_pkg::HEX_W-1:0]       hex_text
);

  localparam int unsigned CH_W  = hsvrgb_pkg::CH_W;
  localparam int unsigned HUE_W = hsvrgb_pkg::HUE_W;
  localparam int unsigned NUM_W = hsvrgb_pkg::NUM_W;
  localparam int unsigned MAG_W = hsvrgb_pkg::MAG_W;
  localparam int unsigned Q_W   = hsvrgb_pkg::DIV_PROD_W - hsvrgb_pkg::DIV_SHIFT;

  // Channel floor and ceiling, kept as bytes.
  logic [CH_W-1:0] low;
  logic [CH_W-1:0] high;
  logic [hsvrgb_pkg::PCT_W-1:0] wr_pct;

  assign wr_pct = (wr_data > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX : wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      low  <= '0;
      high <= '1;
    end else if (wr_en) begin
      unique case (hsvrgb_pkg::cfg_index_t'(wr_index))
        hsvrgb_pkg::CFG_SATURATION: low  <= hsvrgb_pkg::pct_to_byte(hsvrgb_pkg::PCT_MAX - wr_pct);
        hsvrgb_pkg::CFG_BRIGHTNESS: high <= hsvrgb_pkg::pct_to_byte(wr_pct);
      endcase
    end
  end

  assign busy = 1'b0;

  // Input register.
  logic             in_valid;
  logic [HUE_W-1:0] hue_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      hue_q <= hue;
    end
  end

  // Numerator stage: 120*high - 60*low - (high - low) * |hue - center|.
  logic [HUE_W-1:0]        center [3];
  logic [HUE_W-1:0]        hue_dist [3];
  logic signed [HUE_W:0]   dist_s [3];
  logic signed [HUE_W:0]   span;
  logic signed [NUM_W-1:0] base;
  logic signed [NUM_W-1:0] prod   [3];
  logic signed [NUM_W-1:0] num_next [3];
  logic signed [NUM_W-1:0] num    [3];
  logic                    num_valid;

  always_comb begin
    center[0] = (hue_q < hsvrgb_pkg::RED_SPLIT) ? hsvrgb_pkg::RED_CENTER_LO
                                                : hsvrgb_pkg::RED_CENTER_HI;
    center[1] = hsvrgb_pkg::GREEN_CENTER;
    center[2] = hsvrgb_pkg::BLUE_CENTER;
    span = $signed({2'b00, high}) - $signed({2'b00, low});
    base = $signed(NUM_W'(high) * hsvrgb_pkg::HIGH_WEIGHT - NUM_W'(low) * hsvrgb_pkg::LOW_WEIGHT);
    for (int k = 0; k < 3; k++) begin
      hue_dist[k] = (hue_q >= center[k]) ? (hue_q - center[k]) : (center[k] - hue_q);
      dist_s[k]   = $signed({1'b0, hue_dist[k]});
      prod[k]     = span * dist_s[k];
      num_next[k] = base - prod[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_valid <= 1'b0;
    end else begin
      num_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      num[k] <= num_next[k];
    end
  end

  // Divide stage: truncating division by 60 on the magnitude, then clamp.
  logic [MAG_W-1:0]                      mag  [3];
  logic [hsvrgb_pkg::DIV_PROD_W-1:0]     qprod [3];
  logic [Q_W-1:0]                        quot [3];
  logic signed [NUM_W-1:0]               tval [3];
  logic signed [NUM_W-1:0]               low_s;
  logic signed [NUM_W-1:0]               high_s;
  logic [CH_W-1:0]                       chan [3];
  logic [hsvrgb_pkg::HEX_W-1:0]          text_next;

  always_comb begin
    low_s  = $signed(NUM_W'(low));
    high_s = $signed(NUM_W'(high));
    for (int k = 0; k < 3; k++) begin
      mag[k]   = num[k][NUM_W-1] ? MAG_W'(-num[k]) : num[k][MAG_W-1:0];
      qprod[k] = hsvrgb_pkg::DIV_PROD_W'(mag[k]) *
                 hsvrgb_pkg::DIV_PROD_W'(hsvrgb_pkg::DIV60_RECIP);
      quot[k]  = qprod[k][hsvrgb_pkg::DIV_SHIFT +: Q_W];
      tval[k]  = num[k][NUM_W-1] ? -$signed(NUM_W'(quot[k])) : $signed(NUM_W'(quot[k]));
      if (tval[k] < low_s) begin
        chan[k] = low;
      end else if (tval[k] > high_s) begin
        chan[k] = high;
      end else begin
        chan[k] = tval[k][CH_W-1:0];
      end
    end
    text_next = {hsvrgb_pkg::hex_char(chan[0][7:4]), hsvrgb_pkg::hex_char(chan[0][3:0]),
                 hsvrgb_pkg::hex_char(chan[1][7:4]), hsvrgb_pkg::hex_char(chan[1][3:0]),
                 hsvrgb_pkg::hex_char(chan[2][7:4]), hsvrgb_pkg::hex_char(chan[2][3:0])};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= num_valid;
    end
  end

  always_ff @(posedge clk) begin
    red      <= chan[0];
    green    <= chan[1];
    blue     <= chan[2];
    hex_text <= text_next;
  end

  // Every result comes from an earlier input transfer.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(start, 3))
    else $error("result without a matching input transfer");

  // The text follows the red byte that goes out with it.
  assert property (@(posedge clk) disable iff (rst)
    done |-> hex_text[47:40] == hsvrgb_pkg::hex_char(red[7:4]) &&
             hex_text[39:32] == hsvrgb_pkg::hex_char(red[3:0]))
    else $error("hex text does not match red byte");

  // The last character is always a lower-case hex digit.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (hex_text[7:0] >= 8'h30 && hex_text[7:0] <= 8'h39) ||
             (hex_text[7:0] >= 8'h61 && hex_text[7:0] <= 8'h66))
    else $error("hex text holds a character that is not a hex digit");

endmodule

`default_nettype wire

@@ sim/tb_hsv_to_rgb_hex_unit.sv @@
`timescale 1ns / 1ps

module tb_hsv_to_rgb_hex_unit;

  typedef enum {ACT_HUE, ACT_CFG, ACT_SETTLE} action_t;

  typedef struct {
    action_t                          kind;
    logic [hsvrgb_pkg::HUE_W-1:0]     angle;
    hsvrgb_pkg::cfg_index_t           index;
    logic [hsvrgb_pkg::PCT_W-1:0]     value;
    int                               idle_pct;
  } action_entry_t;

  typedef struct {
    logic [hsvrgb_pkg::CH_W-1:0]  red;
    logic [hsvrgb_pkg::CH_W-1:0]  green;
    logic [hsvrgb_pkg::CH_W-1:0]  blue;
    logic [hsvrgb_pkg::HEX_W-1:0] hex_text;
  } color_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic [hsvrgb_pkg::HUE_W-1:0] hue = '0;
  logic                         wr_en = 1'b0;
  hsvrgb_pkg::cfg_index_t       wr_index = hsvrgb_pkg::CFG_SATURATION;
  logic [hsvrgb_pkg::PCT_W-1:0] wr_data = '0;
  logic                         busy;
  logic                         done;
  logic [hsvrgb_pkg::CH_W-1:0]  red;
  logic [hsvrgb_pkg::CH_W-1:0]  green;
  logic [hsvrgb_pkg::CH_W-1:0]  blue;
  logic [hsvrgb_pkg::HEX_W-1:0] hex_text;

  action_entry_t                pending_actions[$];
  color_t                       expected_colors[$];
  logic [hsvrgb_pkg::PCT_W-1:0] sat_pct = hsvrgb_pkg::PCT_MAX;
  logic [hsvrgb_pkg::PCT_W-1:0] val_pct = hsvrgb_pkg::PCT_MAX;
  int                           error_count = 0;

  hsv_to_rgb_hex_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .hue      (hue),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .done     (done),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .hex_text (hex_text)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One channel: a tent around its center, truncated toward zero, then clamped
  // against the floor first and the ceiling second.
  function automatic logic [hsvrgb_pkg::CH_W-1:0] channel_level(input int center,
                                                                input int angle,
                                                                input int lo_lvl,
                                                                input int hi_lvl);
    int hue_dist;
    int lvl;
    hue_dist = angle - center;
    if (hue_dist < 0) begin
      hue_dist = -hue_dist;
    end
    lvl = (120 * hi_lvl - 60 * lo_lvl - (hi_lvl - lo_lvl) * hue_dist) / 60;
    if (lvl < lo_lvl) begin
      lvl = lo_lvl;
    end else if (lvl > hi_lvl) begin
      lvl = hi_lvl;
    end
    return hsvrgb_pkg::CH_W'(lvl);
  endfunction

  function automatic color_t predict_color(input logic [hsvrgb_pkg::HUE_W-1:0] angle,
                                           input logic [hsvrgb_pkg::PCT_W-1:0] sat,
                                           input logic [hsvrgb_pkg::PCT_W-1:0] val);
    int          a;
    int          lo_lvl;
    int          hi_lvl;
    logic [23:0] word;
    logic [3:0]  nib;
    color_t      c;
    a = int'(angle);
    lo_lvl = ((100 - int'(sat)) * 255) / 100;
    hi_lvl = (int'(val) * 255) / 100;
    c.red = channel_level((a < 180) ? 0 : 360, a, lo_lvl, hi_lvl);
    c.green = channel_level(120, a, lo_lvl, hi_lvl);
    c.blue = channel_level(240, a, lo_lvl, hi_lvl);
    word = {c.red, c.green, c.blue};
    c.hex_text = '0;
    for (int k = 5; k >= 0; k--) begin
      nib = word[4*k +: 4];
      c.hex_text = {c.hex_text[hsvrgb_pkg::HEX_W-9:0],
                    (nib < 4'd10) ? (8'h30 + 8'(nib)) : (8'h61 + 8'(nib) - 8'd10)};
    end
    return c;
  endfunction

  always @(posedge clk) begin : drive
    logic                         nxt_start;
    logic [hsvrgb_pkg::HUE_W-1:0] nxt_hue;
    logic                         nxt_wr;
    hsvrgb_pkg::cfg_index_t       nxt_index;
    logic [hsvrgb_pkg::PCT_W-1:0] nxt_data;
    logic [hsvrgb_pkg::PCT_W-1:0] clipped;
    action_entry_t                act;
    nxt_start = start;
    nxt_hue = hue;
    nxt_wr = 1'b0;
    nxt_index = wr_index;
    nxt_data = wr_data;
    if (rst) begin
      nxt_start = 1'b0;
    end else begin
      if (wr_en) begin
        clipped = (wr_data > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX : wr_data;
        case (wr_index)
          hsvrgb_pkg::CFG_SATURATION: sat_pct = clipped;
          hsvrgb_pkg::CFG_BRIGHTNESS: val_pct = clipped;
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_colors.push_back(predict_color(hue, sat_pct, val_pct));
        nxt_start = 1'b0;
      end
      if (!nxt_start && pending_actions.size() > 0) begin
        act = pending_actions[0];
        case (act.kind)
          ACT_HUE: begin
            if ($urandom_range(99) >= act.idle_pct) begin
              nxt_start = 1'b1;
              nxt_hue = act.angle;
              void'(pending_actions.pop_front());
            end
          end
          ACT_CFG: begin
            // Registers change only once the pipeline has emptied.
            if (expected_colors.size() == 0) begin
              nxt_wr = 1'b1;
              nxt_index = act.index;
              nxt_data = act.value;
              void'(pending_actions.pop_front());
            end
          end
          ACT_SETTLE: begin
            if (expected_colors.size() == 0) begin
              void'(pending_actions.pop_front());
            end
          end
          default: ;
        endcase
      end
    end
    start <= nxt_start;
    hue <= nxt_hue;
    wr_en <= nxt_wr;
    wr_index <= nxt_index;
    wr_data <= nxt_data;
  end

  always @(posedge clk) begin : observe
    color_t want;
    if (!rst && done) begin
      if (expected_colors.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d", red, green, blue);
        error_count++;
      end else begin
        want = expected_colors.pop_front();
        if (red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, red);
          error_count++;
        end
        if (green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, green);
          error_count++;
        end
        if (blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, blue);
          error_count++;
        end
        if (hex_text !== want.hex_text) begin
          $error("hex_text: expected %h, got %h", want.hex_text, hex_text);
          error_count++;
        end
      end
    end
  end

  task automatic add_hue(input logic [hsvrgb_pkg::HUE_W-1:0] angle, input int idle_pct);
    action_entry_t act;
    act.kind = ACT_HUE;
    act.angle = angle;
    act.index = hsvrgb_pkg::CFG_SATURATION;
    act.value = '0;
    act.idle_pct = idle_pct;
    pending_actions.push_back(act);
  endtask

  task automatic add_write(input hsvrgb_pkg::cfg_index_t index,
                           input logic [hsvrgb_pkg::PCT_W-1:0] value);
    action_entry_t act;
    act.kind = ACT_CFG;
    act.angle = '0;
    act.index = index;
    act.value = value;
    act.idle_pct = 0;
    pending_actions.push_back(act);
  endtask

  function automatic logic [hsvrgb_pkg::PCT_W-1:0] random_pct();
    logic [hsvrgb_pkg::PCT_W-1:0] v;
    case ($urandom_range(5))
      0: v = 7'd0;
      1: v = hsvrgb_pkg::PCT_MAX;
      2: v = hsvrgb_pkg::PCT_W'($urandom_range(127, 101));
      default: v = hsvrgb_pkg::PCT_W'($urandom_range(100));
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int                           idle_levels[3];
    action_entry_t                settle;
    logic [hsvrgb_pkg::HUE_W-1:0] angle;
    idle_levels = '{0, 73, 32};

    // Directed: segment edges, both red centers, hues past 360, then the
    // saturating register write and a floor above the ceiling.
    add_hue(9'd0, 0);
    add_hue(9'd1, 0);
    add_hue(9'd59, 0);
    add_hue(9'd60, 0);
    add_hue(9'd61, 0);
    add_hue(9'd119, 0);
    add_hue(9'd120, 0);
    add_hue(9'd179, 0);
    add_hue(9'd180, 0);
    add_hue(9'd240, 0);
    add_hue(9'd300, 0);
    add_hue(9'd359, 0);
    add_hue(9'd360, 0);
    add_hue(9'd361, 0);
    add_hue(9'd511, 0);
    add_write(hsvrgb_pkg::CFG_SATURATION, 7'd0);
    add_write(hsvrgb_pkg::CFG_BRIGHTNESS, 7'd127);
    add_hue(9'd0, 0);
    add_hue(9'd180, 0);
    add_hue(9'd300, 0);
    add_write(hsvrgb_pkg::CFG_SATURATION, 7'd50);
    add_write(hsvrgb_pkg::CFG_BRIGHTNESS, 7'd30);
    add_hue(9'd0, 0);
    add_hue(9'd90, 0);
    add_hue(9'd240, 0);
    add_hue(9'd450, 0);

    for (int ph = 0; ph < 3; ph++) begin
      for (int s = 0; s < 4; s++) begin
        add_write(hsvrgb_pkg::CFG_SATURATION, random_pct());
        add_write(hsvrgb_pkg::CFG_BRIGHTNESS, random_pct());
        for (int n = 0; n < 40; n++) begin
          if ($urandom_range(9) == 0) begin
            angle = hsvrgb_pkg::HUE_W'($urandom_range(511, 361));
          end else begin
            angle = hsvrgb_pkg::HUE_W'($urandom_range(360));
          end
          add_hue(angle, idle_levels[ph]);
          if (ph == 1 && s == 2 && n == 20) begin
            settle.kind = ACT_SETTLE;
            settle.angle = '0;
            settle.index = hsvrgb_pkg::CFG_SATURATION;
            settle.value = '0;
            settle.idle_pct = 0;
            pending_actions.push_back(settle);
          end
        end
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_actions.size() != 0 || start || expected_colors.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1600000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/hsvrgb_pkg.sv
hdl/hsv_to_rgb_hex_unit.sv
sim/tb_hsv_to_rgb_hex_unit.sv
